// ===== sv/mps_pkg.sv =====
// shared constants, types and helpers for the matrix power block
`timescale 1ns / 1ps
`default_nettype none
package mps_pkg;

  localparam int MAX_DIM   = 8;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 30;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = 4;
  localparam int EXP_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIM_W-1:0]  dim_t;

  // commands from the sequencer to the datapath, one slot per cycle
  typedef struct packed {
    addr_t rd_a_addr;
    addr_t rd_b_addr;
    logic  mac_valid;
    logic  mac_first;
    logic  mac_last;
    logic  mac_bsel;
    addr_t mac_waddr;
    logic  copy_valid;
    logic  copy_from_base;
    logic  copy_to_base;
    logic  id_we;
    addr_t id_addr;
    logic  id_one;
    logic  load_we;
    addr_t load_addr;
    logic  emit_rd;
    logic  emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // row-major address of element (row, col) in an n by n matrix
  function automatic addr_t elem_addr(idx_t row, idx_t col, dim_t n);
    logic [2*DIM_W-1:0] p;
    p = (2*DIM_W)'(row) * (2*DIM_W)'(n) + (2*DIM_W)'(col);
    return p[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/mps_ctrl.sv =====
// sequencer: loading, squaring loop, copy sweeps and result readout
`timescale 1ns / 1ps
`default_nettype none
module mps_ctrl (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire                             in_last,
  output logic                            in_stall,
  input  wire                             cfg_wen,
  input  wire  [mps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [mps_pkg::CFG_W-1:0]       cfg_data,
  input  mps_pkg::dp_status_t             status,
  output mps_pkg::dp_cmd_t                cmd
);
  import mps_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_IDENT = 4'd2;
  localparam logic [3:0] S_COPY  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]       state;
  logic [3:0]       wait_ret;
  logic [3:0]       copy_ret;
  logic [1:0]       wait_cnt;
  addr_t            pos;
  addr_t            k;
  idx_t             i, j, t;
  logic [EXP_W-1:0] e_left;
  logic             mul_sq;
  logic             copy_src;
  logic             copy_dst;
  dim_t             dim;
  logic [EXP_W-1:0] exp_reg;

  dim_t  n;
  idx_t  n_m1;
  addr_t last_idx;
  logic  in_xfer;

  always_comb begin
    if (dim == '0) begin
      n = DIM_W'(1);
    end else if (dim > DIM_W'(MAX_DIM)) begin
      n = DIM_W'(MAX_DIM);
    end else begin
      n = dim;
    end
    n_m1     = IDX_W'(n - DIM_W'(1));
    last_idx = elem_addr(n_m1, n_m1, n);
  end

  assign in_stall = (state != S_LOAD);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim     <= DIM_W'(MAX_DIM);
      exp_reg <= EXP_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_DIM: dim     <= cfg_data[DIM_W-1:0];
        REG_EXP: exp_reg <= cfg_data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load_addr = pos;
    cmd.load_we   = in_xfer && (pos <= last_idx);
    unique case (state)
      S_MUL: begin
        cmd.rd_a_addr = elem_addr(i, t, n);
        cmd.rd_b_addr = elem_addr(t, j, n);
        cmd.mac_valid = 1'b1;
        cmd.mac_first = (t == '0);
        cmd.mac_last  = (t == n_m1);
        cmd.mac_bsel  = !mul_sq;
        cmd.mac_waddr = elem_addr(i, j, n);
      end
      S_COPY: begin
        cmd.rd_a_addr      = k;
        cmd.copy_valid     = 1'b1;
        cmd.copy_from_base = copy_src;
        cmd.copy_to_base   = copy_dst;
      end
      S_IDENT: begin
        cmd.id_we   = 1'b1;
        cmd.id_addr = elem_addr(i, j, n);
        cmd.id_one  = (i == j);
      end
      S_EMIT: begin
        cmd.rd_b_addr = k;
        cmd.emit_rd   = !status.out_busy;
        cmd.emit_last = (k == last_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      wait_ret <= S_LOAD;
      copy_ret <= S_LOAD;
      wait_cnt <= '0;
      pos      <= '0;
      k        <= '0;
      i        <= '0;
      j        <= '0;
      t        <= '0;
      e_left   <= '0;
      mul_sq   <= 1'b0;
      copy_src <= 1'b0;
      copy_dst <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (in_last) begin
              pos   <= '0;
              state <= S_START;
            end else begin
              pos <= pos + ADDR_W'(1);
            end
          end
        end
        S_START: begin
          i <= '0;
          j <= '0;
          k <= '0;
          if (exp_reg == '0) begin
            state <= S_IDENT;
          end else begin
            e_left   <= exp_reg - EXP_W'(1);
            copy_src <= 1'b1;
            copy_dst <= 1'b0;
            copy_ret <= S_CHECK;
            state    <= S_COPY;
          end
        end
        S_IDENT: begin
          if (j == n_m1) begin
            j <= '0;
            if (i == n_m1) begin
              k        <= '0;
              wait_cnt <= '1;
              wait_ret <= S_EMIT;
              state    <= S_WAIT;
            end else begin
              i <= i + IDX_W'(1);
            end
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_COPY: begin
          k <= k + ADDR_W'(1);
          if (k == last_idx) begin
            wait_cnt <= '1;
            wait_ret <= copy_ret;
            state    <= S_WAIT;
          end
        end
        S_CHECK: begin
          i <= '0;
          j <= '0;
          t <= '0;
          k <= '0;
          if (e_left == '0) begin
            state <= S_EMIT;
          end else if (e_left[0]) begin
            mul_sq <= 1'b0;
            state  <= S_MUL;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          i <= '0;
          j <= '0;
          t <= '0;
          k <= '0;
          if (e_left == EXP_W'(1)) begin
            e_left <= '0;
            state  <= S_EMIT;
          end else begin
            e_left <= e_left >> 1;
            mul_sq <= 1'b1;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (t == n_m1) begin
            t <= '0;
            if (j == n_m1) begin
              j <= '0;
              if (i == n_m1) begin
                // drain the mac pipe, then move scratch into the target
                k        <= '0;
                copy_src <= 1'b0;
                copy_dst <= mul_sq;
                copy_ret <= mul_sq ? S_CHECK : S_STEP;
                wait_cnt <= '1;
                wait_ret <= S_COPY;
                state    <= S_WAIT;
              end else begin
                i <= i + IDX_W'(1);
              end
            end else begin
              j <= j + IDX_W'(1);
            end
          end else begin
            t <= t + IDX_W'(1);
          end
        end
        S_WAIT: begin
          wait_cnt <= wait_cnt - 2'd1;
          if (wait_cnt == '0) begin
            state <= wait_ret;
          end
        end
        S_EMIT: begin
          if (!status.out_busy) begin
            k <= k + ADDR_W'(1);
            if (k == last_idx) begin
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/mps_datapath.sv =====
// matrix stores, shared multiply-accumulate pipe and output register
`timescale 1ns / 1ps
`default_nettype none
module mps_datapath (
  input  wire                          clk,
  input  wire                          rst,
  input  mps_pkg::dp_cmd_t             cmd,
  output mps_pkg::dp_status_t          status,
  input  wire  [mps_pkg::DATA_W-1:0]   in_value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [mps_pkg::DATA_W-1:0]   out_value,
  output logic                         out_last
);
  import mps_pkg::*;

  localparam int TERM_W = 2 * DATA_W - FRAC_BITS;
  localparam int ACC_W  = TERM_W + IDX_W + 1;
  localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] base_mem    [DEPTH];
  logic [DATA_W-1:0] result_mem  [DEPTH];
  logic [DATA_W-1:0] scratch_mem [DEPTH];

  logic [DATA_W-1:0] base_rd_a, base_rd_b, res_rd, scr_rd;

  // stage 1: read data valid
  logic  s1_mac, s1_first, s1_last, s1_bsel;
  addr_t s1_waddr;
  logic  s1_copy, s1_from_base, s1_to_base;
  addr_t s1_addr;
  // stage 2: product valid
  logic  s2_mac, s2_first, s2_last;
  addr_t s2_waddr;
  // stage 3: finished dot product
  logic  s3_wr;
  addr_t s3_waddr;

  logic signed [2*DATA_W-1:0] prod;
  logic signed [TERM_W-1:0]   term;
  logic signed [ACC_W-1:0]    acc;
  logic [DATA_W-1:0]          b_op;
  logic [DATA_W-1:0]          copy_data;
  logic [DATA_W-1:0]          acc_sat;
  logic                       emit_pend;
  logic                       emit_last_d;

  assign b_op      = s1_bsel ? res_rd : base_rd_b;
  assign copy_data = s1_from_base ? base_rd_a : scr_rd;
  // floor of the product to the fraction point
  assign term      = prod[2*DATA_W-1:FRAC_BITS];

  always_comb begin
    if (acc[ACC_W-1:DATA_W-1] == '0 || acc[ACC_W-1:DATA_W-1] == '1) begin
      acc_sat = acc[DATA_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_sat = MIN_VAL;
    end else begin
      acc_sat = MAX_VAL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      base_mem[cmd.load_addr] <= in_value;
    end else if (s1_copy && s1_to_base) begin
      base_mem[s1_addr] <= copy_data;
    end
    base_rd_a <= base_mem[cmd.rd_a_addr];
    base_rd_b <= base_mem[cmd.rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.id_we) begin
      result_mem[cmd.id_addr] <= cmd.id_one ? ONE_VAL : '0;
    end else if (s1_copy && !s1_to_base) begin
      result_mem[s1_addr] <= copy_data;
    end
    res_rd <= result_mem[cmd.rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (s3_wr) begin
      scratch_mem[s3_waddr] <= acc_sat;
    end
    scr_rd <= scratch_mem[cmd.rd_a_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_mac  <= 1'b0;
      s1_copy <= 1'b0;
      s2_mac  <= 1'b0;
      s3_wr   <= 1'b0;
    end else begin
      s1_mac  <= cmd.mac_valid;
      s1_copy <= cmd.copy_valid;
      s2_mac  <= s1_mac;
      s3_wr   <= s2_mac && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first     <= cmd.mac_first;
    s1_last      <= cmd.mac_last;
    s1_bsel      <= cmd.mac_bsel;
    s1_waddr     <= cmd.mac_waddr;
    s1_from_base <= cmd.copy_from_base;
    s1_to_base   <= cmd.copy_to_base;
    s1_addr      <= cmd.rd_a_addr;
    prod         <= $signed(base_rd_a) * $signed(b_op);
    s2_first     <= s1_first;
    s2_last      <= s1_last;
    s2_waddr     <= s1_waddr;
    s3_waddr     <= s2_waddr;
    if (s2_mac) begin
      acc <= (s2_first ? ACC_W'(0) : acc)
           + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
    end
  end

  // one readout in flight at a time, lands in the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      emit_pend <= cmd.emit_rd;
      if (emit_pend) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_last_d <= cmd.emit_last;
    if (emit_pend) begin
      out_value <= res_rd;
      out_last  <= emit_last_d;
    end
  end

  assign status.out_busy = out_valid || emit_pend;

endmodule
`default_nettype wire

// ===== sv/matrix_power_by_squaring.sv =====
// top level: matrix power by repeated squaring, signed Q2.30
//
// Input channel: one matrix element per transfer (in_value, row-major),
// in_last on the final one. The block takes dim*dim elements at one per
// cycle; extra elements before in_last are dropped until the load position
// wraps after 64 transfers and writes again from the first entry; missing
// ones keep the previous contents of the base store. After the transfer
// with in_last the block holds in_stall high until the last result element
// has been read from the result store. Compute: a copy of the base into the
// result store, then per matrix product a pass on the single shared
// multiplier, a mac pipe drain and a copy sweep back from scratch; there
// are at most two products per exponent bit. An exponent of zero writes
// the identity. Output channel: dim*dim elements, row-major, out_last on
// the final one, one at a time, the next read only once the previous one
// has been taken. While out_stall is high the output register holds its
// element and readout waits. Loading of the next matrix may start while
// the last result still waits there. Configuration (dim_in_use index 0,
// exponent index 1) is to be written only while idle; the user must keep
// to this, the block itself does not enforce it. Reset (rst, synchronous)
// restores dim 8 and exponent 1; the matrix stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module matrix_power_by_squaring (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [mps_pkg::DATA_W-1:0]     in_value,
  input  wire                            in_last,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [mps_pkg::DATA_W-1:0]     out_value,
  output logic                           out_last,
  input  wire                            cfg_wen,
  input  wire  [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [mps_pkg::CFG_W-1:0]      cfg_data
);
  import mps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  mps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

// ===== sv/mps_checker.sv =====
// port-level checks for the matrix power block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mps_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         in_valid,
  input wire                         in_stall,
  input wire                         in_last,
  input wire                         out_valid,
  input wire                         out_stall,
  input wire [mps_pkg::DATA_W-1:0]   out_value,
  input wire                         out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // readout keeps a single element in flight
  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("back-to-back result transfer");

  // final element starts the computation, input closes
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input open after final element");

endmodule

bind matrix_power_by_squaring mps_checker u_mps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_value (out_value),
  .out_last  (out_last)
);
`default_nettype wire

// ===== test/testbench.sv =====
// testbench for matrix_power_by_squaring: Q2.30 matrix powers checked against a local predictor
`timescale 1ns / 1ps
module testbench;
  import mps_pkg::*;

  localparam int RANDOM_ITEMS = 140;
  localparam int SETTLE = 8;
  localparam longint WORD_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam logic signed [DATA_W-1:0] FX_ONE = 1 <<< FRAC_BITS;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } power_elem_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_value = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_value;
  logic                 out_last;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic signed [DATA_W-1:0] base_mat [DEPTH];
  logic signed [DATA_W-1:0] power_mat [DEPTH];
  logic signed [DATA_W-1:0] scratch_mat [DEPTH];
  bit                       ever_loaded [DEPTH];
  logic [ADDR_W-1:0]        load_pos = '0;
  logic [DIM_W-1:0]         dim_reg = 4'd8;
  logic [EXP_W-1:0]         exp_reg = 16'd1;

  power_elem_t power_elems_due [$];
  power_elem_t due_head;

  int send_idle_pct = 15;
  int recv_idle_pct = 56;
  int mismatch_count = 0;
  int results_checked = 0;
  int elems_sent = 0;
  int matrices_done = 0;
  int max_exp_used = 0;

  matrix_power_by_squaring DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .out_last(out_last),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int used_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return int'(dim_reg);
  endfunction

  function automatic logic [DATA_W-1:0] clamp_word(longint acc);
    if (acc > WORD_MAX) return DATA_W'(WORD_MAX);
    if (acc < WORD_MIN) return DATA_W'(WORD_MIN);
    return DATA_W'(acc);
  endfunction

  // scratch := base * (base or power), then copied back over the right-hand operand
  task automatic base_times(input bit by_self, input int n);
    longint acc;
    logic signed [DATA_W-1:0] rhs;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int t = 0; t < n; t++) begin
          rhs = by_self ? base_mat[t*n + j] : power_mat[t*n + j];
          // floor of the product at FRAC_BITS fraction bits
          acc += (longint'(base_mat[i*n + t]) * longint'(rhs)) >>> FRAC_BITS;
        end
        scratch_mat[i*n + j] = clamp_word(acc);
      end
    for (int k = 0; k < n * n; k++)
      if (by_self) base_mat[k] = scratch_mat[k];
      else power_mat[k] = scratch_mat[k];
  endtask

  task automatic predict_power();
    int n;
    logic [EXP_W-1:0] left;
    power_elem_t elem;
    n = used_dim();
    if (exp_reg == 0) begin
      for (int k = 0; k < n * n; k++)
        power_mat[k] = (k / n == k % n) ? FX_ONE : '0;
    end else begin
      for (int k = 0; k < n * n; k++)
        power_mat[k] = base_mat[k];
      left = exp_reg - 1'b1;
      while (left != 0) begin
        if (left[0]) base_times(1'b0, n);
        if (left == 1) break;
        left = left >> 1;
        base_times(1'b1, n);
      end
    end
    for (int k = 0; k < n * n; k++) begin
      elem.value = power_mat[k];
      elem.last = (k == n * n - 1);
      power_elems_due.push_back(elem);
    end
    matrices_done++;
  endtask

  task automatic load_element(input logic [DATA_W-1:0] v, input logic last);
    int n;
    n = used_dim();
    if (int'(load_pos) < n * n) begin
      base_mat[load_pos] = v;
      ever_loaded[load_pos] = 1'b1;
    end
    load_pos = load_pos + 1'b1;
    if (last) begin
      load_pos = '0;
      predict_power();
    end
  endtask

  // --------------------------------------------------------- drive and check

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (power_elems_due.size() == 0) begin
        $display("%0t: unexpected result transfer value %h last %b",
                 $time, out_value, out_last);
        mismatch_count++;
      end else begin
        due_head = power_elems_due.pop_front();
        results_checked++;
        if (out_value !== due_head.value) begin
          $display("%0t: out_value expected %h actual %h", $time, due_head.value, out_value);
          mismatch_count++;
        end
        if (out_last !== due_head.last) begin
          $display("%0t: out_last expected %b actual %b", $time, due_head.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_elem(input logic [DATA_W-1:0] v, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    elems_sent++;
    load_element(v, last);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_DIM) dim_reg = val[DIM_W-1:0];
    else begin
      exp_reg = val[EXP_W-1:0];
      if (int'(exp_reg) > max_exp_used) max_exp_used = int'(exp_reg);
    end
    @(posedge clk);
  endtask

  // wait until every predicted element has come out, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (power_elems_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(int n);
    int unsigned lim;
    lim = (32'd1 << FRAC_BITS) / n;
    case ($urandom_range(9))
      0: case ($urandom_range(4))
           0: return 32'h7fff_ffff;
           1: return 32'h8000_0000;
           2: return 32'h4000_0000;
           3: return 32'hc000_0000;
           default: return '0;
         endcase
      1, 2: return $urandom();
      default: return DATA_W'($urandom_range(2 * lim) - lim);
    endcase
  endfunction

  // fewest elements that leave no never-written entry inside the matrix
  function automatic int min_load_count();
    int n, c;
    n = used_dim();
    c = 1;
    for (int k = 0; k < n * n; k++)
      if (!ever_loaded[k]) c = k + 1;
    return c;
  endfunction

  task automatic send_matrix(input int count);
    int n;
    n = used_dim();
    for (int k = 0; k < count; k++)
      send_elem(pick_value(n), k == count - 1);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r <= 12) return CFG_W'(1 + r % 4);
    if (r <= 17) return CFG_W'(r - 8);
    return CFG_W'($urandom_range(8, 15));
  endfunction

  function automatic logic [CFG_W-1:0] pick_exponent();
    bit cheap;
    cheap = (used_dim() <= 4);
    case ($urandom_range(9))
      0: return '0;
      1: return 16'd1;
      8: return cheap ? CFG_W'($urandom_range(65535)) : CFG_W'($urandom_range(21, 255));
      9: return cheap ? 16'hffff : 16'd255;
      default: return CFG_W'($urandom_range(2, 20));
    endcase
  endfunction

  // ------------------------------------------------------------------- tests

  task automatic test_single_elements();
    wait_idle();
    write_reg(REG_DIM, 16'd1);
    send_elem(32'h8000_0000, 1'b1);
    send_elem(32'h7fff_ffff, 1'b1);
    send_elem(32'h0000_0000, 1'b1);
  endtask

  task automatic test_saturation();
    wait_idle();
    write_reg(REG_DIM, 16'd2);
    write_reg(REG_EXP, 16'd2);
    send_elem(32'h7fff_ffff, 1'b0);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h4000_0000, 1'b0);
    send_elem(32'hc000_0000, 1'b1);
  endtask

  task automatic test_zero_exponent();
    wait_idle();
    write_reg(REG_EXP, 16'd0);
    send_elem(32'h1234_5678, 1'b1);
  endtask

  task automatic test_dim_zero();
    wait_idle();
    write_reg(REG_DIM, 16'd0);
    write_reg(REG_EXP, 16'd3);
    send_elem(32'h6000_0000, 1'b1);
  endtask

  // dimension above the maximum, plus a load long enough to wrap the position
  task automatic test_oversize_and_wrap();
    wait_idle();
    write_reg(REG_DIM, 16'd9);
    write_reg(REG_EXP, 16'd2);
    send_matrix(DEPTH + 2);
  endtask

  // short load: the tail of the matrix keeps the base store contents from the previous load
  task automatic test_short_load();
    wait_idle();
    write_reg(REG_DIM, 16'd3);
    write_reg(REG_EXP, 16'd5);
    send_matrix(2);
  endtask

  task automatic test_long_exponents();
    wait_idle();
    write_reg(REG_DIM, 16'd2);
    write_reg(REG_EXP, 16'hffff);
    send_matrix(4);
    wait_idle();
    write_reg(REG_DIM, 16'd1);
    write_reg(REG_EXP, 16'h8000);
    send_elem(32'h3fff_ffff, 1'b1);
  endtask

  task automatic test_random_matrices();
    int first_item, done, n, count;
    first_item = elems_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 56;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // new settings only once the block has drained
      if (done == 0 || $urandom_range(9) < 4) begin
        wait_idle();
        write_reg(REG_DIM, pick_dim());
        write_reg(REG_EXP, pick_exponent());
      end
      n = used_dim();
      if ($urandom_range(9) < 7) count = n * n;
      else count = $urandom_range(min_load_count(), n * n + 3);
      send_matrix(count);
      done = elems_sent - first_item;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_elements();
    test_saturation();
    test_zero_exponent();
    test_dim_zero();
    test_oversize_and_wrap();
    test_short_load();
    test_long_exponents();
    test_random_matrices();
    wait_idle();
    repeat (200) @(posedge clk);
    $display("covered %0d matrices from %0d element transfers, %0d result transfers checked",
             matrices_done, elems_sent, results_checked);
    $display("dims 0 to 15 incl. clamped ones, exponents 0 to %0d, short and overlong loads",
             max_exp_used);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
